[rtl/core/rlc_receive_pdu_processor_defines.svh]
// Assertion macros shared by the receive PDU processor RTL.
`ifndef RLC_RECEIVE_PDU_PROCESSOR_DEFINES_SVH
`define RLC_RECEIVE_PDU_PROCESSOR_DEFINES_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define RLCRX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rlcrx assertion failed");
// Check prop at every rising edge, reset included.
`define RLCRX_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rlcrx assertion failed");
`else
`define RLCRX_ASSERT(lbl, clk, rst, prop)
`define RLCRX_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/rlcrx_pkg.sv]
// Types and constants of the RLC receive PDU processor.
package rlcrx_pkg;

   // Mode register codes
   localparam logic [1:0] MODE_TM = 2'd0;
   localparam logic [1:0] MODE_UM = 2'd1;
   localparam logic [1:0] MODE_AM = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_SDU    = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] KIND_ACK    = 2'd3;

   // Header fields of the first AM header byte
   localparam int DC_BIT_POS   = 7;
   localparam int POLL_BIT_POS = 6;

   // Byte position within a PDU, stops at two
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_BODY   = 2'd2;

   localparam int RES_DEPTH = 3;

   typedef struct packed {
      logic [11:0] expected_sn;
      logic [11:0] acked_sn;
      logic [1:0]  byte_pos;
      logic [7:0]  first_hdr;
      logic        deliver;
      logic        poll;
   } rx_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } res_entry_type;

endpackage

[rtl/core/rlcrx_decode.sv]
// Per-word header decode, sequence check and result generation.
module rlcrx_decode import rlcrx_pkg::*; (
   input  logic [1:0]                       rlc_mode,
   input  logic [7:0]                       pdu_byte,
   input  logic                             pdu_last,
   input  rx_state_type                     state_cur,
   output rx_state_type                     state_nxt,
   output res_entry_type [RES_DEPTH-1:0]    res,
   output logic [1:0]                       res_cnt
);

   always_comb begin
      rx_state_type  st;
      logic          p_valid;
      res_entry_type p_res;
      logic          status;
      logic [11:0]   sn;
      res_entry_type st_hi;
      res_entry_type st_lo;

      st      = state_cur;
      p_valid = 1'b0;
      p_res   = '{kind: KIND_SDU, data: pdu_byte, last: pdu_last};
      status  = 1'b0;
      sn      = {st.first_hdr[3:0], pdu_byte};

      // capture header byte and clear flags on the first word of a PDU
      if (state_cur.byte_pos == POS_FIRST) begin
         st.first_hdr = pdu_byte;
         st.deliver   = 1'b0;
         st.poll      = 1'b0;
      end
      sn = {st.first_hdr[3:0], pdu_byte};

      case (rlc_mode)
         MODE_TM: begin
            p_valid = 1'b1;
         end
         MODE_UM: begin
            if (state_cur.byte_pos == POS_FIRST) begin
               if (pdu_byte[6:0] == st.expected_sn[6:0]) begin
                  st.deliver     = 1'b1;
                  st.expected_sn = {5'd0, st.expected_sn[6:0] + 7'd1};
                  if (pdu_last) begin
                     p_valid = 1'b1;
                     p_res   = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
                  end
               end
            end else if (st.deliver) begin
               p_valid = 1'b1;
            end
         end
         MODE_AM: begin
            if (state_cur.byte_pos == POS_SECOND) begin
               if (!st.first_hdr[DC_BIT_POS]) begin
                  // control PDU: take the acknowledged number
                  st.acked_sn = sn;
                  st.deliver  = 1'b0;
                  st.poll     = 1'b0;
                  p_valid     = 1'b1;
                  p_res       = '{kind: KIND_ACK, data: 8'd0, last: 1'b0};
               end else begin
                  st.poll = st.first_hdr[POLL_BIT_POS];
                  if (sn == st.expected_sn) begin
                     st.deliver     = 1'b1;
                     st.expected_sn = st.expected_sn + 12'd1;
                     if (pdu_last) begin
                        p_valid = 1'b1;
                        p_res   = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
                     end
                  end
               end
            end else if (state_cur.byte_pos == POS_BODY) begin
               p_valid = st.deliver;
            end
            status = pdu_last && st.poll && (state_cur.byte_pos != POS_FIRST);
         end
         default: begin
            // unused mode: drop the word
         end
      endcase

      // STATUS PDU carries the expected number after this word
      st_hi = '{kind: KIND_STATUS, data: {4'd0, st.expected_sn[11:8]}, last: 1'b0};
      st_lo = '{kind: KIND_STATUS, data: st.expected_sn[7:0], last: 1'b1};

      // advance or clear the byte position
      if (pdu_last) begin
         st.byte_pos = POS_FIRST;
         st.deliver  = 1'b0;
         st.poll     = 1'b0;
      end else if (state_cur.byte_pos != POS_BODY) begin
         st.byte_pos = state_cur.byte_pos + 2'd1;
      end

      state_nxt = st;

      // pack results, primary first
      if (p_valid) begin
         res[0] = p_res;
         res[1] = st_hi;
         res[2] = st_lo;
      end else begin
         res[0] = st_hi;
         res[1] = st_lo;
         res[2] = st_lo;
      end
      res_cnt = {1'b0, p_valid} + (status ? 2'd2 : 2'd0);
   end

endmodule

[rtl/core/rlc_receive_pdu_processor.sv]
// Top level of the RLC receive PDU processor.
// Receive side of one RLC entity, one PDU byte per word. A word is decoded
// in the cycle it is taken and its zero to three results are loaded into a
// three-entry result buffer that drains one result per cycle while rsp_ready
// is high. A new word is taken when the buffer is empty or its last result
// is taken in the same cycle: one word per cycle while each word gives at
// most one result and rsp_ready stays high; a word that ends a polled PDU
// gives up to three results, which hold off the next word. The result buffer
// sets the word rate. rsp_ack_sn always shows the acknowledged number after
// the word whose results are on the port. Write the mode only while idle.
`include "rlc_receive_pdu_processor_defines.svh"
module rlc_receive_pdu_processor import rlcrx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pdu_byte,
   input  logic        req_pdu_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_unit_last,
   output logic [11:0] rsp_ack_sn,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_rlc_mode
);

   logic [1:0]                    mode_ff;
   rx_state_type                  state_ff;
   rx_state_type                  state_in;
   res_entry_type [RES_DEPTH-1:0] res_ff;
   res_entry_type [RES_DEPTH-1:0] res_in;
   logic [1:0]                    cnt_ff;
   logic [1:0]                    cnt_in;
   res_entry_type [RES_DEPTH-1:0] dec_res;
   logic [1:0]                    dec_cnt;
   rx_state_type                  dec_state;
   logic                          req_fire;
   logic                          rsp_fire;

   // decode the incoming word against the current state
   rlcrx_decode u_decode (
      .rlc_mode  (mode_ff),
      .pdu_byte  (req_pdu_byte),
      .pdu_last  (req_pdu_last),
      .state_cur (state_ff),
      .state_nxt (dec_state),
      .res       (dec_res),
      .res_cnt   (dec_cnt)
   );

   // handshakes
   assign csr_ready = 1'b1;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // head of the result buffer drives the port
   assign rsp_result_kind = res_ff[0].kind;
   assign rsp_data_byte   = res_ff[0].data;
   assign rsp_unit_last   = res_ff[0].last;
   assign rsp_ack_sn      = state_ff.acked_sn;

   // load a new batch or advance the buffer
   always_comb begin
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      state_in = state_ff;
      if (req_fire) begin
         res_in   = dec_res;
         cnt_in   = dec_cnt;
         state_in = dec_state;
      end else if (rsp_fire) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   // control and entity state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TM;
         state_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_rlc_mode;
         end
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   `RLCRX_ASSERT(a_no_take_when_full, clock, reset, (cnt_ff > 2'd1) |-> !req_ready)
   `RLCRX_ASSERT(a_status_pair, clock, reset,
      (rsp_fire && rsp_result_kind == KIND_STATUS && !rsp_unit_last) |=>
      (rsp_valid && rsp_result_kind == KIND_STATUS && rsp_unit_last))
   `RLCRX_ASSERT(a_last_clears_pos, clock, reset,
      (req_fire && req_pdu_last) |=> (state_ff.byte_pos == POS_FIRST && !state_ff.deliver))
   `RLCRX_ASSERT_ALWAYS(a_pos_saturates, clock, reset || (state_ff.byte_pos != 2'd3))

endmodule
